>>> hdl/bdp_pkg.sv
// Package for the binomial downsample block: shared constants and types.
// Used by bdp_pos and by the top level; has no dependencies.
`timescale 1ns / 1ps

package bdp_pkg;

    // configuration register
    localparam int CFG_W = 4;
    localparam logic [CFG_W-1:0] CFG_RESET     = 4'd8;
    localparam logic [CFG_W-1:0] SIZE_LOG2_MIN = 4'd2;

    // width of the output grid index fields
    localparam int OUT_IDX_W = 7;

    // number of recent rows kept in the row store
    localparam int ROW_SLOTS = 3;
    localparam int SLOT_W    = 2;

    // one column of the window: recent rows, current sample, first two rows
    localparam int COL_LEN   = 5;
    localparam int COL_IDX_W = 3;
    localparam logic [COL_IDX_W-1:0] COL_OLD  = 3'd0;  // row r-2
    localparam logic [COL_IDX_W-1:0] COL_PREV = 3'd1;  // row r-1
    localparam logic [COL_IDX_W-1:0] COL_CUR  = 3'd2;  // row r, this word
    localparam logic [COL_IDX_W-1:0] COL_F0   = 3'd3;  // grid row 0
    localparam logic [COL_IDX_W-1:0] COL_F1   = 3'd4;  // grid row 1

    // per-word position flags from the position counter
    typedef struct packed {
        logic has_a;       // window of (i, j) completes here
        logic has_c;       // last column: wrapped window (i, 0) completes
        logic last_row;    // last grid row: row 0 outputs follow
        logic col_zero;    // column 0 of a row
        logic col_one;     // column 1 of a row
        logic head_write;  // grid row 0 or 1: copy into first-row store
    } t_pos_flags;

endpackage

>>> hdl/bdp_ram.sv
// Generic simple dual-port RAM: one write port, two registered read ports.
// No dependencies.
`timescale 1ns / 1ps

module bdp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered reads, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

>>> hdl/bdp_pos.sv
// Grid position counter with the grid size register and per-word flags.
// Depends on bdp_pkg.
`timescale 1ns / 1ps

module bdp_pos #(
    parameter int MAX_SIZE_LOG2 = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [bdp_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                       i_advance,
    output logic [MAX_SIZE_LOG2-1:0]   o_row,
    output logic [MAX_SIZE_LOG2-1:0]   o_col,
    output logic [bdp_pkg::SLOT_W-1:0] o_slot,
    output logic [bdp_pkg::SLOT_W-1:0] o_slot_m1,
    output logic [bdp_pkg::SLOT_W-1:0] o_slot_m2,
    output bdp_pkg::t_pos_flags        o_flags
);

    import bdp_pkg::*;

    logic [CFG_W-1:0]         r_size_log2;
    logic [CFG_W-1:0]         eff_log2;
    logic [MAX_SIZE_LOG2-1:0] side_mask;
    logic [MAX_SIZE_LOG2-1:0] r_row;
    logic [MAX_SIZE_LOG2-1:0] r_col;
    logic [SLOT_W-1:0]        r_slot;
    logic [MAX_SIZE_LOG2-1:0] n_row;
    logic [MAX_SIZE_LOG2-1:0] n_col;
    logic [SLOT_W-1:0]        n_slot;
    logic                     emit_ok;

    // grid size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_log2 <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_size_log2 <= i_cfg_data;
        end
    end

    // clamp the size and build the side mask S-1
    always_comb begin
        if (r_size_log2 < SIZE_LOG2_MIN) begin
            eff_log2 = SIZE_LOG2_MIN;
        end else if (r_size_log2 > CFG_W'(MAX_SIZE_LOG2)) begin
            eff_log2 = CFG_W'(MAX_SIZE_LOG2);
        end else begin
            eff_log2 = r_size_log2;
        end
        for (int k = 0; k < MAX_SIZE_LOG2; k++) begin
            side_mask[k] = (CFG_W'(k) < eff_log2);
        end
    end

    // next position; a config write starts a new grid
    always_comb begin
        n_row  = r_row;
        n_col  = r_col;
        n_slot = r_slot;
        if (i_cfg_we) begin
            n_row  = '0;
            n_col  = '0;
            n_slot = '0;
        end else if (i_advance) begin
            if (r_col == side_mask) begin
                n_col = '0;
                if (r_row == side_mask) begin
                    n_row  = '0;
                    n_slot = '0;
                end else begin
                    n_row  = r_row + 1'b1;
                    n_slot = (r_slot == SLOT_W'(ROW_SLOTS - 1)) ? '0 : r_slot + 1'b1;
                end
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_slot <= '0;
        end else begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_slot <= n_slot;
        end
    end

    // slots of the two rows above the current one
    always_comb begin
        case (r_slot)
            2'd0: begin
                o_slot_m1 = 2'd2;
                o_slot_m2 = 2'd1;
            end
            2'd1: begin
                o_slot_m1 = 2'd0;
                o_slot_m2 = 2'd2;
            end
            default: begin
                o_slot_m1 = 2'd1;
                o_slot_m2 = 2'd0;
            end
        endcase
    end

    // odd row from 3 up, odd column
    assign emit_ok = r_row[0] && (|r_row[MAX_SIZE_LOG2-1:1]) && r_col[0];

    always_comb begin
        o_flags.has_a      = emit_ok && (|r_col[MAX_SIZE_LOG2-1:1]);
        o_flags.has_c      = emit_ok && (r_col == side_mask);
        o_flags.last_row   = (r_row == side_mask);
        o_flags.col_zero   = (r_col == '0);
        o_flags.col_one    = (r_col == MAX_SIZE_LOG2'(1));
        o_flags.head_write = ~(|r_row[MAX_SIZE_LOG2-1:1]);
    end

    assign o_row  = r_row;
    assign o_col  = r_col;
    assign o_slot = r_slot;

endmodule

>>> hdl/bdp_filter.sv
// 3x3 binomial weighted sum, each term truncated toward zero on its own.
// Combinational; no dependencies.
`timescale 1ns / 1ps

module bdp_filter #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic signed [SAMPLE_WIDTH-1:0] i_win [3][3],
    output logic signed [SAMPLE_WIDTH-1:0] o_value
);

    localparam int SUM_W = SAMPLE_WIDTH + 4;

    logic signed [SUM_W-1:0] row_sum [3];
    logic signed [SUM_W-1:0] total;

    // arithmetic shift with rounding toward zero
    function automatic logic signed [SAMPLE_WIDTH-1:0] trunc_shift(
        input logic signed [SAMPLE_WIDTH-1:0] v,
        input logic [2:0]                     k
    );
        logic signed [SAMPLE_WIDTH-1:0] bias;
        bias = v[SAMPLE_WIDTH-1] ? ((SAMPLE_WIDTH'(1) << k) - SAMPLE_WIDTH'(1)) : '0;
        return (v + bias) >>> k;
    endfunction

    // corners /16, edges /8, center /4
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            row_sum[r] = SUM_W'(trunc_shift(i_win[r][0], (r == 1) ? 3'd3 : 3'd4))
                       + SUM_W'(trunc_shift(i_win[r][1], (r == 1) ? 3'd2 : 3'd3))
                       + SUM_W'(trunc_shift(i_win[r][2], (r == 1) ? 3'd3 : 3'd4));
        end
        total = row_sum[0] + row_sum[1] + row_sum[2];
    end

    // weights sum to one, so the result stays in sample range
    assign o_value = total[SAMPLE_WIDTH-1:0];

endmodule

>>> hdl/binomial_downsample_periodic.sv
// Top level of the periodic 3x3 binomial filter with downsampling by two.
// Depends on bdp_pkg, bdp_ram, bdp_pos and bdp_filter.
`timescale 1ns / 1ps

// Takes one sample per cycle while o_stall is low, from a square grid of side
// 2^grid_size_log2 in row-major order, and returns the half-size grid of 3x3
// binomial sums with periodic wrap; results go from stage 1 into the result
// register. Most samples give zero or one result; the single result register
// sends one word per cycle while i_stall is low, so a sample with several
// results holds the input until its last one is loaded (up to four at the
// last sample of a grid: (S/2-1,S/2-1), (0,S/2-1), (S/2-1,0), (0,0)). Writing
// grid_size_log2 restarts the grid at the next sample; values are clamped to
// 2..MAX_SIZE_LOG2. The last three rows and the first two rows of the grid
// live in two RAMs that need no clearing after reset.
module binomial_downsample_periodic #(
    parameter int MAX_SIZE_LOG2 = 8,
    parameter int SAMPLE_WIDTH  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_value,
    output logic [bdp_pkg::OUT_IDX_W-1:0] o_out_row,
    output logic [bdp_pkg::OUT_IDX_W-1:0] o_out_col,
    output logic                          o_grid_done,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bdp_pkg::CFG_W-1:0]     i_cfg_grid_size_log2
);

    import bdp_pkg::*;

    localparam int SMAX = 1 << MAX_SIZE_LOG2;
    localparam int HW   = MAX_SIZE_LOG2 - 1;

    // bit positions of the pending result mask, in emission order
    localparam int JOB_MAIN      = 0;
    localparam int JOB_HEAD      = 1;
    localparam int JOB_WRAP      = 2;
    localparam int JOB_WRAP_HEAD = 3;

    logic                     cfg_we;
    logic                     accept;
    logic [MAX_SIZE_LOG2-1:0] pos_row;
    logic [MAX_SIZE_LOG2-1:0] pos_col;
    logic [SLOT_W-1:0]        pos_slot;
    logic [SLOT_W-1:0]        pos_slot_m1;
    logic [SLOT_W-1:0]        pos_slot_m2;
    t_pos_flags               pos_flags;

    logic [SAMPLE_WIDTH-1:0]  rec_m1;
    logic [SAMPLE_WIDTH-1:0]  rec_m2;
    logic [SAMPLE_WIDTH-1:0]  first0;
    logic [SAMPLE_WIDTH-1:0]  first1;

    logic                     r_s1_valid;
    logic [3:0]               r_pend;
    logic [3:0]               n_pend;
    logic [3:0]               pend_next;
    logic [3:0]               cur_bit;
    logic [SAMPLE_WIDTH-1:0]  r_s1_sample;
    t_pos_flags               r_s1_flags;
    logic [HW-1:0]            r_s1_i;
    logic [HW-1:0]            r_s1_j;

    logic signed [SAMPLE_WIDTH-1:0] cur_col [COL_LEN];
    logic signed [SAMPLE_WIDTH-1:0] r_cm1   [COL_LEN];
    logic signed [SAMPLE_WIDTH-1:0] r_cm2   [COL_LEN];
    logic signed [SAMPLE_WIDTH-1:0] r_c0    [COL_LEN];
    logic signed [SAMPLE_WIDTH-1:0] r_c1    [COL_LEN];
    logic signed [SAMPLE_WIDTH-1:0] col_l   [COL_LEN];
    logic signed [SAMPLE_WIDTH-1:0] col_m   [COL_LEN];
    logic signed [SAMPLE_WIDTH-1:0] col_r   [COL_LEN];
    logic signed [SAMPLE_WIDTH-1:0] win     [3][3];
    logic signed [SAMPLE_WIDTH-1:0] filt_value;

    logic [COL_IDX_W-1:0]     sel_top;
    logic [COL_IDX_W-1:0]     sel_mid;
    logic [COL_IDX_W-1:0]     sel_bot;
    logic                     is_wrap;
    logic                     is_head;
    logic [HW+OUT_IDX_W-1:0]  ext_i;
    logic [HW+OUT_IDX_W-1:0]  ext_j;

    logic                     out_free;
    logic                     out_load;
    logic                     s1_retire;
    logic                     r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_value;
    logic [OUT_IDX_W-1:0]     r_out_row;
    logic [OUT_IDX_W-1:0]     r_out_col;
    logic                     r_out_done;

    // config port is always ready
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid & o_cfg_ready;

    // handshake between input, stage 1 and the result register
    assign out_free  = !r_out_valid || !i_stall;
    assign out_load  = r_s1_valid && (r_pend != '0) && out_free;
    assign cur_bit   = r_pend & (~r_pend + 4'd1);
    assign pend_next = r_pend & ~cur_bit;
    assign s1_retire = (r_s1_valid && (r_pend == '0)) || (out_load && (pend_next == '0));
    assign o_stall   = r_s1_valid && !s1_retire;
    assign accept    = i_valid && !o_stall;

    bdp_pos #(
        .MAX_SIZE_LOG2(MAX_SIZE_LOG2)
    ) u_pos (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (i_cfg_grid_size_log2),
        .i_advance  (accept),
        .o_row      (pos_row),
        .o_col      (pos_col),
        .o_slot     (pos_slot),
        .o_slot_m1  (pos_slot_m1),
        .o_slot_m2  (pos_slot_m2),
        .o_flags    (pos_flags)
    );

    // last three rows, slot = row mod 3
    bdp_ram #(
        .WIDTH(SAMPLE_WIDTH),
        .DEPTH(ROW_SLOTS * SMAX)
    ) u_recent_ram (
        .i_clk     (i_clk),
        .i_we      (accept),
        .i_waddr   ({pos_slot, pos_col}),
        .i_wdata   (i_sample),
        .i_re      (accept),
        .i_raddr_a ({pos_slot_m1, pos_col}),
        .i_raddr_b ({pos_slot_m2, pos_col}),
        .o_rdata_a (rec_m1),
        .o_rdata_b (rec_m2)
    );

    // grid rows 0 and 1, read for the row 0 outputs at the last row
    bdp_ram #(
        .WIDTH(SAMPLE_WIDTH),
        .DEPTH(2 * SMAX)
    ) u_first_ram (
        .i_clk     (i_clk),
        .i_we      (accept && pos_flags.head_write),
        .i_waddr   ({pos_row[0], pos_col}),
        .i_wdata   (i_sample),
        .i_re      (accept),
        .i_raddr_a ({1'b0, pos_col}),
        .i_raddr_b ({1'b1, pos_col}),
        .o_rdata_a (first0),
        .o_rdata_b (first1)
    );

    // results this word completes
    always_comb begin
        n_pend                = '0;
        n_pend[JOB_MAIN]      = pos_flags.has_a;
        n_pend[JOB_HEAD]      = pos_flags.has_a && pos_flags.last_row;
        n_pend[JOB_WRAP]      = pos_flags.has_c;
        n_pend[JOB_WRAP_HEAD] = pos_flags.has_c && pos_flags.last_row;
    end

    // stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_pend     <= '0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
            r_pend     <= n_pend;
        end else begin
            if (s1_retire) begin
                r_s1_valid <= 1'b0;
            end
            if (out_load) begin
                r_pend <= pend_next;
            end
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_sample <= i_sample;
            r_s1_flags  <= pos_flags;
            r_s1_i      <= pos_row[MAX_SIZE_LOG2-1:1];
            r_s1_j      <= pos_col[MAX_SIZE_LOG2-1:1];
        end
    end

    // current column of the window
    always_comb begin
        cur_col[COL_OLD]  = signed'(rec_m2);
        cur_col[COL_PREV] = signed'(rec_m1);
        cur_col[COL_CUR]  = signed'(r_s1_sample);
        cur_col[COL_F0]   = signed'(first0);
        cur_col[COL_F1]   = signed'(first1);
    end

    // column history: two previous columns plus columns 0 and 1 for the wrap
    always_ff @(posedge i_clk) begin
        if (s1_retire) begin
            r_cm2 <= r_cm1;
            r_cm1 <= cur_col;
            if (r_s1_flags.col_zero) begin
                r_c0 <= cur_col;
            end
            if (r_s1_flags.col_one) begin
                r_c1 <= cur_col;
            end
        end
    end

    // window for the result being sent
    assign is_wrap = cur_bit[JOB_WRAP] | cur_bit[JOB_WRAP_HEAD];
    assign is_head = cur_bit[JOB_HEAD] | cur_bit[JOB_WRAP_HEAD];

    always_comb begin
        sel_top = is_head ? COL_CUR : COL_OLD;
        sel_mid = is_head ? COL_F0  : COL_PREV;
        sel_bot = is_head ? COL_F1  : COL_CUR;
        for (int k = 0; k < COL_LEN; k++) begin
            col_l[k] = is_wrap ? cur_col[k] : r_cm2[k];
            col_m[k] = is_wrap ? r_c0[k]    : r_cm1[k];
            col_r[k] = is_wrap ? r_c1[k]    : cur_col[k];
        end
        win[0][0] = col_l[sel_top];
        win[0][1] = col_m[sel_top];
        win[0][2] = col_r[sel_top];
        win[1][0] = col_l[sel_mid];
        win[1][1] = col_m[sel_mid];
        win[1][2] = col_r[sel_mid];
        win[2][0] = col_l[sel_bot];
        win[2][1] = col_m[sel_bot];
        win[2][2] = col_r[sel_bot];
    end

    bdp_filter #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_filter (
        .i_win   (win),
        .o_value (filt_value)
    );

    // output grid indexes, masked to the field width
    assign ext_i = {{OUT_IDX_W{1'b0}}, (is_head ? {HW{1'b0}} : r_s1_i)};
    assign ext_j = {{OUT_IDX_W{1'b0}}, (is_wrap ? {HW{1'b0}} : r_s1_j)};

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_value <= filt_value;
            r_out_row   <= ext_i[OUT_IDX_W-1:0];
            r_out_col   <= ext_j[OUT_IDX_W-1:0];
            r_out_done  <= cur_bit[JOB_WRAP_HEAD];
        end
    end

    assign o_valid     = r_out_valid;
    assign o_value     = r_out_value;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_grid_done = r_out_done;

endmodule

>>> hdl/bdp_checker.sv
// Port-level assertions for binomial_downsample_periodic, bound to the top.
// Depends on bdp_pkg and the top level's port names.
`timescale 1ns / 1ps

module bdp_checker #(
    parameter int SAMPLE_WIDTH = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_stall,
    input logic                          o_valid,
    input logic [SAMPLE_WIDTH-1:0]       o_value,
    input logic [bdp_pkg::OUT_IDX_W-1:0] o_out_row,
    input logic [bdp_pkg::OUT_IDX_W-1:0] o_out_col,
    input logic                          o_grid_done
);

    // reset empties the result register
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // grid end is flagged only on output (0,0)
    a_done_at_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_grid_done |-> (o_out_row == '0) && (o_out_col == '0))
        else $error("grid_done on a word other than (0,0)");

    // a grid end is never directly followed by another
    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_grid_done && !i_stall |=> !(o_valid && o_grid_done))
        else $error("two grid_done words in a row");

    // stalled result word holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_value) && $stable(o_out_row)
            && $stable(o_out_col) && $stable(o_grid_done))
        else $error("stalled result word changed");

endmodule

bind binomial_downsample_periodic bdp_checker #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_bdp_checker (.*);

>>> sim/downsample_checker.sv
// Checker for binomial_downsample_periodic: mirrors the filter on each accepted sample
// and compares every output word with the oldest predicted word.
// Depends on bdp_pkg for the register width and the index field width.
`timescale 1ns / 1ps

module downsample_checker #(
    parameter int MAX_SIZE_LOG2 = 8,
    parameter int SAMPLE_WIDTH  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_sample,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_value,
    input  logic [bdp_pkg::OUT_IDX_W-1:0]     i_out_row,
    input  logic [bdp_pkg::OUT_IDX_W-1:0]     i_out_col,
    input  logic                              i_grid_done,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [bdp_pkg::CFG_W-1:0]         i_cfg_size,
    output int                                o_fail_count,
    output int                                o_pending
);

    localparam int SMAX  = 1 << MAX_SIZE_LOG2;
    localparam int IDX_W = bdp_pkg::OUT_IDX_W;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] value;
        logic [bdp_pkg::OUT_IDX_W-1:0]  row;
        logic [bdp_pkg::OUT_IDX_W-1:0]  col;
        logic                           done;
    } t_out_word;

    // mirrored state of the block
    int                        head_rows   [2*SMAX];
    int                        recent_rows [3*SMAX];
    logic [MAX_SIZE_LOG2-1:0]  row_pos;
    logic [MAX_SIZE_LOG2-1:0]  col_pos;
    logic [bdp_pkg::CFG_W-1:0] size_reg;

    t_out_word queued_outputs[$];
    int        mismatches = 0;

    assign o_fail_count = mismatches;

    // side length in use, clamped to the supported range
    function automatic int side_log2(input logic [bdp_pkg::CFG_W-1:0] v);
        if (v < bdp_pkg::SIZE_LOG2_MIN)
            return bdp_pkg::SIZE_LOG2_MIN;
        if (v > MAX_SIZE_LOG2)
            return MAX_SIZE_LOG2;
        return v;
    endfunction

    // rows 0 and 1 come from the head store when the output sits in row 0
    function automatic int window_tap(input int row, input int col, input bit head);
        col = col & (SMAX - 1);
        if (head && row < 2)
            return head_rows[row*SMAX + col];
        return recent_rows[(row % 3)*SMAX + col];
    endfunction

    // 3x3 binomial sum around input (2i,2j), each term truncated on its own
    function automatic int binomial_sum(input int i, input int j, input int s);
        int acc;
        int row;
        int col;
        int shift;
        acc = 0;
        for (int dr = 0; dr < 3; dr++) begin
            row = (2*i + s + dr - 1) & (s - 1);
            for (int dc = 0; dc < 3; dc++) begin
                col   = (2*j + s + dc - 1) & (s - 1);
                shift = (dr == 1 ? 0 : 1) + (dc == 1 ? 0 : 1);
                acc  += window_tap(row, col, i == 0) / (4 << shift);
            end
        end
        return acc;
    endfunction

    // output (i,j), then its row 0 partner on the last grid row
    task automatic push_column(input int i, input int j, input int s, input bit last_row);
        t_out_word w;
        w.value = SAMPLE_WIDTH'(binomial_sum(i, j, s));
        w.row   = IDX_W'(i);
        w.col   = IDX_W'(j);
        w.done  = 1'b0;
        queued_outputs = {queued_outputs, w};
        if (last_row) begin
            w.value = SAMPLE_WIDTH'(binomial_sum(0, j, s));
            w.row   = '0;
            // the wrapped (0,0) word closes the grid
            w.done  = (j == 0);
            queued_outputs = {queued_outputs, w};
        end
    endtask

    task automatic predict_sample(input logic signed [SAMPLE_WIDTH-1:0] smp);
        int s;
        int r;
        int c;
        bit last_row;
        s = 1 << side_log2(size_reg);
        r = row_pos & (s - 1);
        c = col_pos & (s - 1);
        recent_rows[(r % 3)*SMAX + c] = int'(smp);
        if (r < 2)
            head_rows[r*SMAX + c] = int'(smp);
        // odd row and column from the fourth on complete a window
        if ((r % 2) == 1 && r >= 3 && (c % 2) == 1) begin
            last_row = (r == s - 1);
            if (c >= 3)
                push_column((r - 1) / 2, (c - 1) / 2, s, last_row);
            if (c == s - 1)
                push_column((r - 1) / 2, 0, s, last_row);
        end
        c++;
        if (c == s) begin
            c = 0;
            r++;
            if (r == s)
                r = 0;
        end
        row_pos = MAX_SIZE_LOG2'(r);
        col_pos = MAX_SIZE_LOG2'(c);
    endtask

    // watch both channels and the register port
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            row_pos  = '0;
            col_pos  = '0;
            size_reg = bdp_pkg::CFG_RESET;
            queued_outputs.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                size_reg = i_cfg_size;
                row_pos  = '0;
                col_pos  = '0;
            end
            if (i_in_valid && !i_in_stall)
                predict_sample(i_sample);
            if (i_out_valid && !i_out_stall) begin
                if (queued_outputs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output word: value %0d row %0d col %0d done %0b",
                                 i_value, i_out_row, i_out_col, i_grid_done);
                end else begin
                    want = queued_outputs.pop_front();
                    if (i_value !== want.value || i_out_row !== want.row ||
                        i_out_col !== want.col || i_grid_done !== want.done) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"output word mismatch: expected value %0d row %0d ",
                                      "col %0d done %0b, got value %0d row %0d col %0d done %0b"},
                                     $signed(want.value), want.row, want.col, want.done,
                                     i_value, i_out_row, i_out_col, i_grid_done);
                    end
                end
            end
        end
        o_pending <= queued_outputs.size();
    end

endmodule

>>> sim/tb_top.sv
// Testbench top for binomial_downsample_periodic: drives samples and size writes,
// applies random idling on both sides and reports the verdict.
// Depends on bdp_pkg, the block under test and downsample_checker.
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_WAIT  = 8;
    localparam int LONG_HOLD   = 60;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic signed [15:0]            i_sample = '0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic signed [15:0]            o_value;
    logic [bdp_pkg::OUT_IDX_W-1:0] o_out_row;
    logic [bdp_pkg::OUT_IDX_W-1:0] o_out_col;
    logic                          o_grid_done;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [bdp_pkg::CFG_W-1:0]     i_cfg_grid_size_log2 = '0;

    int fail_count;
    int pending_words;
    int cycle_count = 0;
    int words_seen = 0;
    int hold_left = 0;
    bit long_hold_armed = 1'b1;
    bit quiet = 1'b0;

    binomial_downsample_periodic dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_sample             (i_sample),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_value              (o_value),
        .o_out_row            (o_out_row),
        .o_out_col            (o_out_col),
        .o_grid_done          (o_grid_done),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_grid_size_log2 (i_cfg_grid_size_log2)
    );

    downsample_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_sample     (i_sample),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_value      (o_value),
        .i_out_row    (o_out_row),
        .i_out_col    (o_out_col),
        .i_grid_done  (o_grid_done),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_size   (i_cfg_grid_size_log2),
        .o_fail_count (fail_count),
        .o_pending    (pending_words)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // output side: random stall bursts and one long hold-off
    always @(posedge i_clk) begin
        if (o_valid && !i_stall)
            words_seen <= words_seen + 1;
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (long_hold_armed && words_seen >= 10) begin
            long_hold_armed <= 1'b0;
            hold_left       <= LONG_HOLD;
            i_stall         <= 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            hold_left <= $urandom_range(0, 10);
            i_stall   <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // mostly full-range content with the extremes mixed in
    function automatic logic signed [15:0] random_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return '0;
            default: return 16'($urandom);
        endcase
    endfunction

    // offer one word, with an occasional idle burst before it
    task automatic send_sample(input logic signed [15:0] smp);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= smp;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_sample(random_sample());
    endtask

    // stop offering and wait until every predicted word has come out
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // size register write on an idle block
    task automatic write_size(input logic [bdp_pkg::CFG_W-1:0] size_log2);
        drain();
        i_cfg_valid          <= 1'b1;
        i_cfg_grid_size_log2 <= size_log2;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // a few words at the reset size, too few for any output
        send_random(6);

        // size below range acts as 4x4: checkerboard of both extremes
        write_size(4'd0);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                send_sample(((r + c) % 2 != 0) ? 16'sh8000 : 16'sh7FFF);

        // partial grid, then a rewrite restarts the grid mid-row
        write_size(4'd2);
        send_random(9);
        write_size(4'd2);
        for (int k = 0; k < 16; k++)
            case (k % 4)
                0:       send_sample(16'sh8000);
                1:       send_sample(-16'sd1);
                2:       send_sample(16'sd0);
                default: send_sample(16'sh7FFF);
            endcase

        // random grids at small sizes
        write_size(4'd1);
        send_random(32);
        write_size(4'd3);
        send_random(64);
        drain();
        send_random(32);

        // size above range acts as the largest
        write_size(4'd15);
        send_random(24);
        write_size(4'd8);
        send_random(16);

        // last stretch without idling on either side
        quiet = 1'b1;
        write_size(4'd2);
        send_random(32);
        drain();

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
